### rtl/core/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the prime sieve sum block.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int BOUND_W = 16;  // upper_bound field
    localparam int SUM_W   = 28;  // prime_sum field
    localparam int STAT_W  = 2;   // status field
    localparam int P_W     = 9;   // sieving prime, p*p <= 65535 keeps p below 256
    localparam int SQ_W    = 17;  // p squared, can step one past the 16-bit range
    localparam int M_W     = 17;  // running multiple, m + p may pass 65535

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_LOW  = 2'd1,
        STATUS_HIGH = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_PRD,
        S_PCHK,
        S_MARK,
        S_SUM,
        S_SUMEND,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture bound, start a request
        logic clr_wr;    // clear one map entry, advance v
        logic p_init;    // p = 2, sq = 4
        logic p_rd;      // read map entry of p
        logic p_next;    // p = p + 1, sq = (p + 1)^2
        logic m_init;    // m = p * p
        logic mark_wr;   // set map entry of m
        logic m_step;    // m = m + p
        logic v_init;    // v = 2
        logic sum_rd;    // read map entry of v, advance v
        logic out_load;  // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;       // bound out of range
        logic clr_last;  // v has reached the bound
        logic p_done;    // p * p above bound
        logic p_comp;    // map entry just read is marked
        logic m_over;    // m above bound
        logic sum_last;  // v has reached the bound
        logic out_busy;  // output register holds an untaken result
    } t_stat;

endpackage

### rtl/core/pss_ram.sv
// ----------------------------------------------------------------------------
// pss_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pss_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer for clear, mark and sum passes over the composite map.
// ----------------------------------------------------------------------------
module pss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pss_pkg::t_stat i_stat,
    output pss_pkg::t_cmd  o_cmd
);

    pss_pkg::t_state r_state;
    pss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            pss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pss_pkg::S_CLEAR;
                end
            end
            pss_pkg::S_CLEAR: begin
                if (i_stat.err) begin
                    n_state = pss_pkg::S_FINISH;
                end else begin
                    o_cmd.clr_wr = 1'b1;
                    if (i_stat.clr_last) begin
                        o_cmd.p_init = 1'b1;
                        n_state      = pss_pkg::S_PRD;
                    end
                end
            end
            pss_pkg::S_PRD: begin
                if (i_stat.p_done) begin
                    o_cmd.v_init = 1'b1;
                    n_state      = pss_pkg::S_SUM;
                end else begin
                    o_cmd.p_rd = 1'b1;
                    n_state    = pss_pkg::S_PCHK;
                end
            end
            pss_pkg::S_PCHK: begin
                if (i_stat.p_comp) begin
                    o_cmd.p_next = 1'b1;
                    n_state      = pss_pkg::S_PRD;
                end else begin
                    o_cmd.m_init = 1'b1;
                    n_state      = pss_pkg::S_MARK;
                end
            end
            pss_pkg::S_MARK: begin
                if (i_stat.m_over) begin
                    o_cmd.p_next = 1'b1;
                    n_state      = pss_pkg::S_PRD;
                end else begin
                    o_cmd.mark_wr = 1'b1;
                    o_cmd.m_step  = 1'b1;
                end
            end
            pss_pkg::S_SUM: begin
                o_cmd.sum_rd = 1'b1;
                if (i_stat.sum_last) begin
                    n_state = pss_pkg::S_SUMEND;
                end
            end
            pss_pkg::S_SUMEND: begin
                // last read lands in the accumulator this cycle
                n_state = pss_pkg::S_FINISH;
            end
            pss_pkg::S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/pss_datapath.sv
// ----------------------------------------------------------------------------
// pss_datapath
// Counters, composite map RAM, sum accumulator and output register.
// ----------------------------------------------------------------------------
module pss_datapath #(
    parameter int BOUND_LIMIT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pss_pkg::BOUND_W-1:0]  i_upper_bound,
    input  pss_pkg::t_cmd                i_cmd,
    output pss_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pss_pkg::SUM_W-1:0]    o_prime_sum,
    output logic [pss_pkg::STAT_W-1:0]   o_status
);

    localparam int AW = $clog2(BOUND_LIMIT);
    localparam logic [pss_pkg::BOUND_W-1:0] LIMIT = pss_pkg::BOUND_W'(BOUND_LIMIT);

    logic [pss_pkg::BOUND_W-1:0] r_bound, n_bound;
    pss_pkg::t_status            r_status, n_status;
    logic [pss_pkg::BOUND_W-1:0] r_v, n_v;
    logic [pss_pkg::P_W-1:0]     r_p, n_p;
    logic [pss_pkg::SQ_W-1:0]    r_sq, n_sq;
    logic [pss_pkg::M_W-1:0]     r_m, n_m;
    logic [pss_pkg::BOUND_W-1:0] r_pend_v, n_pend_v;
    logic                        r_pend, n_pend;
    logic [pss_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic                        r_out_valid, n_out_valid;
    logic [pss_pkg::SUM_W-1:0]   r_out_sum, n_out_sum;
    pss_pkg::t_status            r_out_status, n_out_status;

    logic [pss_pkg::M_W-1:0]     v_off, p_off, m_off;
    logic [AW-1:0]               ram_addr;
    logic                        ram_rdata;

    // map entry k holds value k + 2
    assign v_off = pss_pkg::M_W'(r_v) - pss_pkg::M_W'(2);
    assign p_off = pss_pkg::M_W'(r_p) - pss_pkg::M_W'(2);
    assign m_off = r_m - pss_pkg::M_W'(2);

    always_comb begin
        priority if (i_cmd.p_rd) begin
            ram_addr = p_off[AW-1:0];
        end else if (i_cmd.mark_wr) begin
            ram_addr = m_off[AW-1:0];
        end else begin
            ram_addr = v_off[AW-1:0];
        end
    end

    pss_ram #(
        .WIDTH (1),
        .DEPTH (BOUND_LIMIT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr | i_cmd.mark_wr),
        .i_addr  (ram_addr),
        .i_wdata (i_cmd.mark_wr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_bound      = r_bound;
        n_status     = r_status;
        n_v          = r_v;
        n_p          = r_p;
        n_sq         = r_sq;
        n_m          = r_m;
        n_pend_v     = r_pend_v;
        n_pend       = i_cmd.sum_rd;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid;
        n_out_sum    = r_out_sum;
        n_out_status = r_out_status;

        if (i_cmd.load) begin
            n_bound = i_upper_bound;
            n_v     = pss_pkg::BOUND_W'(2);
            n_sum   = '0;
            priority if (i_upper_bound < pss_pkg::BOUND_W'(2)) begin
                n_status = pss_pkg::STATUS_LOW;
            end else if (i_upper_bound > LIMIT) begin
                n_status = pss_pkg::STATUS_HIGH;
            end else begin
                n_status = pss_pkg::STATUS_OK;
            end
        end
        if (i_cmd.clr_wr) begin
            n_v = r_v + 1'b1;
        end
        if (i_cmd.p_init) begin
            n_p  = pss_pkg::P_W'(2);
            n_sq = pss_pkg::SQ_W'(4);
        end
        if (i_cmd.p_next) begin
            n_p  = r_p + 1'b1;
            // (p+1)^2 = p^2 + 2p + 1
            n_sq = r_sq + pss_pkg::SQ_W'({r_p, 1'b1});
        end
        if (i_cmd.m_init) begin
            n_m = r_sq;
        end
        if (i_cmd.m_step) begin
            n_m = r_m + pss_pkg::M_W'(r_p);
        end
        if (i_cmd.v_init) begin
            n_v = pss_pkg::BOUND_W'(2);
        end
        if (i_cmd.sum_rd) begin
            n_v      = r_v + 1'b1;
            n_pend_v = r_v;
        end
        if (r_pend && !ram_rdata) begin
            n_sum = r_sum + pss_pkg::SUM_W'(r_pend_v);
        end
        if (i_cmd.out_load) begin
            n_out_valid  = 1'b1;
            n_out_sum    = r_sum;
            n_out_status = r_status;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound      <= n_bound;
        r_status     <= n_status;
        r_v          <= n_v;
        r_p          <= n_p;
        r_sq         <= n_sq;
        r_m          <= n_m;
        r_pend_v     <= n_pend_v;
        r_sum        <= n_sum;
        r_out_sum    <= n_out_sum;
        r_out_status <= n_out_status;
    end

    assign o_stat.err      = (r_status != pss_pkg::STATUS_OK);
    assign o_stat.clr_last = (r_v == r_bound);
    assign o_stat.p_done   = (r_sq > pss_pkg::SQ_W'(r_bound));
    assign o_stat.p_comp   = ram_rdata;
    assign o_stat.m_over   = (r_m > pss_pkg::M_W'(r_bound));
    assign o_stat.sum_last = (r_v == r_bound);
    assign o_stat.out_busy = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_prime_sum = r_out_sum;
    assign o_status    = r_out_status;

endmodule

### rtl/core/prime_sieve_sum_top.sv
// ----------------------------------------------------------------------------
// prime_sieve_sum_top
// Sums all primes from 2 through a requested bound with a bitmap sieve.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries i_upper_bound; output channel
// o_out_valid/i_out_ready returns o_prime_sum and o_status (0 ok, 1 bound
// below two, 2 bound above BOUND_LIMIT; sum is zero unless ok).
// One request is worked at a time. With bound B in range, a request first
// clears map entries 2..B, then for each p with p*p <= B looks up map entry
// p and, for a prime p, marks the multiples of p from p*p up to B, then runs
// the summing pass over 2..B and loads the output. All passes go through the
// single port of the composite map RAM, one access per cycle. Out-of-range
// bounds skip the passes and go straight to loading the output.
// The finished result sits in an output register; o_in_ready returns once it
// is loaded, so the next request can start while the receiver stalls. A new
// result waits in the sequencer until the previous one has been transferred.
// Reset (synchronous, active low) empties the output register and returns to
// idle; the map needs no clearing since every request clears its own range.
// ----------------------------------------------------------------------------
module prime_sieve_sum_top #(
    parameter int BOUND_LIMIT = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pss_pkg::BOUND_W-1:0] i_upper_bound,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pss_pkg::SUM_W-1:0]   o_prime_sum,
    output logic [pss_pkg::STAT_W-1:0]  o_status
);

    pss_pkg::t_cmd  cmd;
    pss_pkg::t_stat stat;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pss_datapath #(
        .BOUND_LIMIT (BOUND_LIMIT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upper_bound (i_upper_bound),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_prime_sum   (o_prime_sum),
        .o_status      (o_status)
    );

endmodule
